### rtl/ssa_pkg.sv
package ssa_pkg;

  // default sizes of the slab pool
  localparam int SLOTS_DEF     = 64;
  localparam int NUM_SLABS_DEF = 16;

  // bitmap words are 64 slots wide, searched one word at a time
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = 6;

  // configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;
  localparam int SLOTS_CFG_W  = 7;
  localparam int LIMIT_CFG_W  = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SLAB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LIMIT     = 1'b1;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RST = 7'd64;
  localparam logic [LIMIT_CFG_W-1:0] LIMIT_CFG_RST = 5'd16;

  // item fields
  localparam int SLAB_NUM_W = 4;
  localparam int SLOT_NUM_W = 6;
  localparam int STATUS_W   = 2;
  localparam int USE_W      = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [SLAB_NUM_W-1:0] slab_number;
    logic [SLOT_NUM_W-1:0] slot_number;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLAB_NUM_W-1:0] granted_slab;
    logic [SLOT_NUM_W-1:0] granted_slot;
    logic [USE_W-1:0]      objects_in_use;
  } out_item_t;

  // answer of the shared first-one finder
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } ffs_res_t;

endpackage

### rtl/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ssa_ffs.sv
module ssa_ffs (
  input  logic [ssa_pkg::WORD_BITS-1:0] vec,
  output ssa_pkg::ffs_res_t             res
);
  import ssa_pkg::*;

  localparam int GRP   = 8;
  localparam int GRP_W = $clog2(GRP);
  localparam int NGRP  = WORD_BITS / GRP;

  logic [NGRP-1:0]  grp_any;
  logic [GRP_W-1:0] grp_idx [NGRP];
  logic [GRP_W-1:0] sel;

  // two levels of eight: lowest set bit inside each group, then lowest group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |vec[g*GRP +: GRP];
      grp_idx[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (vec[g*GRP + b]) begin
          grp_idx[g] = GRP_W'(b);
        end
      end
    end
    sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel = GRP_W'(g);
      end
    end
    res.found = |grp_any;
    res.idx   = IDX_W'({sel, grp_idx[sel]});
  end

endmodule

### rtl/slab_slot_allocator.sv
// Slot allocator for one object cache over a pool of NUM_SLABS slabs of up to SLOTS slots.
// Pulse start with an item while busy is low; the result comes back on out_item with a
// one-cycle out_valid strobe in the first cycle that busy is low again, and it cannot be held
// off, so the receiver must take it then. A new item may be started in the cycle of that strobe.
// One sequencer drives a single 64-bit first-one finder over and over: first across the
// partial-slab flags, then the empty-slab flags, 64 slabs per cycle, then across the slot
// bitmap of the chosen slab one 64-slot word at a time, each word read from the registered
// output of the bitmap memory (S_RD) before it is searched (S_SRCH). When a slab has to be
// activated (also when a partial slab with no slot below the count forces one), its bitmap
// words and fill count are zeroed first. A free reads the bitmap word, then checks and
// writes it back; a free of an inactive slab or an out-of-range slot is refused after the
// range check. Bitmaps are not cleared after reset, only on activation, so the block is
// ready at once. Config writes are always taken (cfg_ready is high) and are meant for idle
// time only.
module slab_slot_allocator #(
  parameter int SLOTS     = ssa_pkg::SLOTS_DEF,
  parameter int NUM_SLABS = ssa_pkg::NUM_SLABS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // item in
  input  logic                               start,
  output logic                               busy,
  input  ssa_pkg::in_item_t                  in_item,
  // result out
  output logic                               out_valid,
  output ssa_pkg::out_item_t                 out_item,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssa_pkg::*;

  // sizes derived from the pool
  localparam int WPS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W   = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int SLOT_W   = WORD_W + IDX_W;
  localparam int NCHUNK   = (NUM_SLABS + WORD_BITS - 1) / WORD_BITS;
  localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD      = NCHUNK * WORD_BITS;
  localparam int SLAB_W   = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int ACT_W    = $clog2(NUM_SLABS + 1);
  localparam int FILL_W   = $clog2(SLOTS + 1);
  localparam int BM_DEPTH = NUM_SLABS * WPS;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,  // flag search for a partial, then an empty slab
    S_ACT  = 9'b000000100,  // take the next unused slab
    S_CLR  = 9'b000001000,  // zero its bitmap words and fill count
    S_RD   = 9'b000010000,  // bitmap word read in flight
    S_SRCH = 9'b000100000,  // first free slot in the word
    S_AWR  = 9'b001000000,  // mark slot used
    S_FRD  = 9'b010000000,  // free: range check, read in flight
    S_FCHK = 9'b100000000   // free: double-free check and write back
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  logic [SLAB_W-1:0]      slab_r, slab_nxt;
  logic [WORD_W-1:0]      word_r, word_nxt;
  logic [CHUNK_W-1:0]     chunk_r, chunk_nxt;
  logic                   phase_r, phase_nxt;        // 0 partial flags, 1 empty flags
  logic                   act_once_r, act_once_nxt;  // slab activated for this item
  logic [ACT_W-1:0]       active_r, active_nxt;
  logic [NUM_SLABS-1:0]   partial_r, partial_nxt;
  logic [NUM_SLABS-1:0]   empty_r, empty_nxt;        // active slabs with no slot in use
  logic [USE_W-1:0]       total_r, total_nxt;
  logic [SLOTS_CFG_W-1:0] slots_cfg_r, slots_cfg_nxt;
  logic [LIMIT_CFG_W-1:0] limit_cfg_r, limit_cfg_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload
  in_item_t               in_r, in_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [WORD_BITS-1:0]   word_data_r, word_data_nxt;
  out_item_t              out_item_r, out_item_nxt;

  // memories and the shared finder
  logic                   bm_we;
  logic [BM_AW-1:0]       bm_addr;
  logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;
  logic                   fill_we;
  logic [FILL_W-1:0]      fill_wdata, fill_rdata;
  logic [WORD_BITS-1:0]   ffs_vec;
  ffs_res_t               ffs_res;

  // derived values
  logic [SLOTS_CFG_W-1:0] n_eff;
  logic                   limit_hit;
  logic [PAD-1:0]         partial_pad, empty_pad;
  logic [WORD_BITS-1:0]   chunk_vec;
  logic [WORD_BITS-1:0]   slot_mask;
  int                     mask_rem;
  logic [FILL_W-1:0]      fill_inc, fill_dec;
  logic                   free_bad;
  logic [WORD_BITS-1:0]   alloc_bit, free_bit;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // slots in use per slab never exceed the pool width
  assign n_eff     = (32'(slots_cfg_r) > SLOTS) ? SLOTS_CFG_W'(SLOTS) : slots_cfg_r;
  assign limit_hit = (32'(active_r) >= 32'(limit_cfg_r)) || (32'(active_r) >= NUM_SLABS);

  assign partial_pad = PAD'(partial_r);
  assign empty_pad   = PAD'(empty_r);
  assign chunk_vec   = phase_r ? empty_pad[chunk_r*WORD_BITS +: WORD_BITS]
                               : partial_pad[chunk_r*WORD_BITS +: WORD_BITS];

  // slots of this word that lie below the slot count
  always_comb begin
    mask_rem = int'(n_eff) - int'(word_r) * WORD_BITS;
    if (mask_rem >= WORD_BITS) begin
      slot_mask = '1;
    end else if (mask_rem <= 0) begin
      slot_mask = '0;
    end else begin
      slot_mask = (WORD_BITS'(1) << mask_rem) - WORD_BITS'(1);
    end
  end

  assign ffs_vec = (state_r == S_SRCH) ? (~bm_rdata & slot_mask) : chunk_vec;

  assign bm_addr    = BM_AW'(32'(slab_r) * WPS + 32'(word_r));
  assign fill_inc   = fill_rdata + FILL_W'(1);
  assign fill_dec   = (fill_rdata == '0) ? '0 : fill_rdata - FILL_W'(1);
  assign free_bad   = (32'(in_r.slab_number) >= 32'(active_r)) ||
                      ({1'b0, in_r.slot_number} >= n_eff);
  assign alloc_bit  = WORD_BITS'(1) << slot_r[IDX_W-1:0];
  assign free_bit   = WORD_BITS'(1) << in_r.slot_number;

  ssa_ffs u_ffs (
    .vec (ffs_vec),
    .res (ffs_res)
  );

  ssa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_addr),
    .wdata (bm_wdata),
    .raddr (bm_addr),
    .rdata (bm_rdata)
  );

  ssa_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_SLABS)
  ) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (slab_r),
    .wdata (fill_wdata),
    .raddr (slab_r),
    .rdata (fill_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    slab_nxt      = slab_r;
    word_nxt      = word_r;
    chunk_nxt     = chunk_r;
    phase_nxt     = phase_r;
    act_once_nxt  = act_once_r;
    active_nxt    = active_r;
    partial_nxt   = partial_r;
    empty_nxt     = empty_r;
    total_nxt     = total_r;
    slots_cfg_nxt = slots_cfg_r;
    limit_cfg_nxt = limit_cfg_r;
    out_valid_nxt = 1'b0;
    in_nxt        = in_r;
    slot_nxt      = slot_r;
    word_data_nxt = word_data_r;
    out_item_nxt  = out_item_r;
    bm_we         = 1'b0;
    bm_wdata      = '0;
    fill_we       = 1'b0;
    fill_wdata    = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOTS_PER_SLAB: slots_cfg_nxt = cfg_data;
        CFG_SLAB_LIMIT:     limit_cfg_nxt = cfg_data[LIMIT_CFG_W-1:0];
        default:            ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_item;
          word_nxt  = '0;
          chunk_nxt = '0;
          phase_nxt = 1'b0;
          if (in_item.opcode == OP_FREE) begin
            slab_nxt  = SLAB_W'(in_item.slab_number);
            state_nxt = S_FRD;
          end else begin
            act_once_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (n_eff == '0) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_NO_SPACE, granted_slab: '0, granted_slot: '0,
                            objects_in_use: total_r};
          state_nxt     = S_IDLE;
        end else if (ffs_res.found) begin
          slab_nxt  = SLAB_W'({chunk_r, ffs_res.idx});
          word_nxt  = '0;
          state_nxt = S_RD;
        end else if (32'(chunk_r) == NCHUNK - 1) begin
          chunk_nxt = '0;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            state_nxt = S_ACT;
          end
        end else begin
          chunk_nxt = chunk_r + CHUNK_W'(1);
        end
      end

      S_ACT: begin
        if (limit_hit) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_NO_SPACE, granted_slab: '0, granted_slot: '0,
                            objects_in_use: total_r};
          state_nxt     = S_IDLE;
        end else begin
          slab_nxt                              = active_r[SLAB_W-1:0];
          empty_nxt[active_r[SLAB_W-1:0]]       = 1'b1;
          partial_nxt[active_r[SLAB_W-1:0]]     = 1'b0;
          active_nxt                            = active_r + ACT_W'(1);
          act_once_nxt                          = 1'b1;
          word_nxt                              = '0;
          state_nxt                             = S_CLR;
        end
      end

      S_CLR: begin
        bm_we      = 1'b1;
        bm_wdata   = '0;
        fill_we    = 1'b1;
        fill_wdata = '0;
        if (32'(word_r) == WPS - 1) begin
          word_nxt  = '0;
          state_nxt = S_RD;
        end else begin
          word_nxt = word_r + WORD_W'(1);
        end
      end

      S_RD: begin
        state_nxt = S_SRCH;
      end

      S_SRCH: begin
        if (ffs_res.found) begin
          slot_nxt      = {word_r, ffs_res.idx};
          word_data_nxt = bm_rdata;
          state_nxt     = S_AWR;
        end else if (32'(word_r) == WPS - 1) begin
          // chosen slab has no room below the current slot count
          if (act_once_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_NO_SPACE, granted_slab: '0, granted_slot: '0,
                              objects_in_use: total_r};
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_ACT;
          end
        end else begin
          word_nxt  = word_r + WORD_W'(1);
          state_nxt = S_RD;
        end
      end

      S_AWR: begin
        bm_we      = 1'b1;
        bm_wdata   = word_data_r | alloc_bit;
        fill_we    = 1'b1;
        fill_wdata = fill_inc;
        empty_nxt[slab_r] = 1'b0;
        // full once the fill reaches the slot count in force now
        partial_nxt[slab_r] = (32'(fill_inc) < 32'(n_eff));
        total_nxt     = total_r + USE_W'(1);
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_DONE, granted_slab: SLAB_NUM_W'(slab_r),
                          granted_slot: slot_r[SLOT_NUM_W-1:0],
                          objects_in_use: total_r + USE_W'(1)};
        state_nxt     = S_IDLE;
      end

      S_FRD: begin
        if (free_bad) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_INVALID, granted_slab: '0, granted_slot: '0,
                            objects_in_use: total_r};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FCHK;
        end
      end

      S_FCHK: begin
        if (!bm_rdata[in_r.slot_number]) begin
          // double free
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_INVALID, granted_slab: '0, granted_slot: '0,
                            objects_in_use: total_r};
        end else begin
          bm_we       = 1'b1;
          bm_wdata    = bm_rdata & ~free_bit;
          fill_we     = 1'b1;
          fill_wdata  = fill_dec;
          empty_nxt[slab_r]   = (fill_dec == '0);
          partial_nxt[slab_r] = (fill_dec != '0);
          total_nxt     = total_r - USE_W'(1);
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_DONE, granted_slab: '0, granted_slot: '0,
                            objects_in_use: total_r - USE_W'(1)};
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slab_r      <= '0;
      word_r      <= '0;
      chunk_r     <= '0;
      phase_r     <= 1'b0;
      act_once_r  <= 1'b0;
      active_r    <= '0;
      partial_r   <= '0;
      empty_r     <= '0;
      total_r     <= '0;
      slots_cfg_r <= SLOTS_CFG_RST;
      limit_cfg_r <= LIMIT_CFG_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slab_r      <= slab_nxt;
      word_r      <= word_nxt;
      chunk_r     <= chunk_nxt;
      phase_r     <= phase_nxt;
      act_once_r  <= act_once_nxt;
      active_r    <= active_nxt;
      partial_r   <= partial_nxt;
      empty_r     <= empty_nxt;
      total_r     <= total_nxt;
      slots_cfg_r <= slots_cfg_nxt;
      limit_cfg_r <= limit_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    slot_r      <= slot_nxt;
    word_data_r <= word_data_nxt;
    out_item_r  <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  // a result only ever follows a cycle of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without an item in work");

  // an accepted item always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a slab is never both partial and empty
  a_class_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r & empty_r) == '0)
    else $error("slab flagged partial and empty at once");

  // active count stays within the pool
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(active_r) <= NUM_SLABS)
    else $error("active slab count beyond pool");
`endif

endmodule
